// ===== design/tbc_pkg.sv =====
`timescale 1ns / 1ps
package tbc_pkg;

  // Field widths fixed by the interface
  localparam int COORD_W = 24;
  localparam int AREA_W  = 40;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;

  // Defaults
  localparam int              DEF_MAX_VERTICES = 64;
  localparam logic [AREA_W-1:0] DEF_MIN_AREA   = AREA_W'(51);

  // Largest polygon that takes vertex 0 without a search
  localparam int SMALL_POLY = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } tbc_state_e;

endpackage

// ===== design/trifan_base_chooser_core.sv =====
`timescale 1ns / 1ps
// Triangle fan base chooser. Vertices of one convex polygon are loaded one
// beat per cycle while busy_o is low; the beat with last_vertex_i set closes
// the polygon. Polygons of three or fewer vertices, and overflowed ones,
// report on result_valid_o in the cycle after the closing beat. Larger
// polygons are searched out of the vertex memory, one read per cycle in
// the scan state: each candidate base costs n+2 reads followed by a pipeline
// drain, and busy_o stays high until the result is shown. The result is
// shown for exactly one cycle and cannot be stalled; the next polygon may
// start loading in that same cycle.
module trifan_base_chooser_core #(
  parameter int MAX_VERTICES = tbc_pkg::DEF_MAX_VERTICES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [tbc_pkg::AREA_W-1:0]    cfg_wdata_i,
  // vertex beats
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [tbc_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [tbc_pkg::COORD_W-1:0] vertex_y_i,
  input  logic                          last_vertex_i,
  // results
  output logic                          result_valid_o,
  output logic                          base_found_o,
  output logic [tbc_pkg::IDX_W-1:0]     base_index_o,
  output logic [tbc_pkg::CNT_W-1:0]     fan_vertex_count_o,
  output logic                          overflow_o
);
  import tbc_pkg::*;

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int PW  = CW + 1;
  localparam int DW  = COORD_W + 1;
  localparam int PRW = 2 * DW;
  localparam int XW  = PRW + 1;
  localparam int MW  = 2 * COORD_W;

  // Vertex memory, {x, y} per entry
  logic [MW-1:0] vtx_mem [MAX_VERTICES];
  logic [MW-1:0] rd_data_q;

  tbc_state_e state_q, state_d;

  logic [AREA_W-1:0] thr_q;
  logic [CW-1:0]     cnt_q;
  logic              ovf_q;
  logic [CW-1:0]     n_q;
  logic [AW-1:0]     b_q;
  logic [PW-1:0]     pos_q;
  logic              ok_q;

  logic              rd_valid_q;
  logic [PW-1:0]     tag_q;

  logic signed [COORD_W-1:0] base_x_q, base_y_q, prev_x_q, prev_y_q;
  logic signed [DW-1:0]      ax_q, ay_q, bx_q, by_q;
  logic                      s1_valid_q, s1_skip_q;
  logic signed [PRW-1:0]     p1_q, p2_q;
  logic                      s2_valid_q, s2_skip_q;

  logic              rv_q, found_q, rovf_q;
  logic [IDX_W-1:0]  ridx_q;
  logic [CNT_W-1:0]  rcnt_q;

  logic              accept, wr_en, ovf_new, last_issue, issue, pipe_empty;
  logic              start_search, search_done, last_base;
  logic [CW-1:0]     n_new;
  logic [AW-1:0]     rd_addr;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic [PW-1:0]     edge_i, edge_j;
  logic              skip;
  logic signed [XW-1:0] cross_val;
  logic [XW-1:0]     cross_abs;

  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign wr_en   = accept && (cnt_q < CW'(MAX_VERTICES));
  assign n_new   = wr_en ? cnt_q + CW'(1) : cnt_q;
  assign ovf_new = ovf_q || !wr_en;

  assign last_issue = (pos_q == PW'(n_q) + PW'(1));
  assign pipe_empty = !rd_valid_q && !s1_valid_q && !s2_valid_q;
  assign last_base  = (b_q == AW'(n_q - CW'(1)));

  // Sequence the scan: base, then ring 0..n-1, then vertex 0 again
  always_comb begin
    state_d      = state_q;
    issue        = 1'b0;
    start_search = 1'b0;
    search_done  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && last_vertex_i && !ovf_new && (n_new > CW'(SMALL_POLY))) begin
          start_search = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          if (ok_q || last_base) begin
            search_done = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (pos_q == '0) begin
      rd_addr = b_q;
    end else if (last_issue) begin
      rd_addr = '0;
    end else begin
      rd_addr = AW'(pos_q - PW'(1));
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vtx_mem[AW'(cnt_q)] <= {vertex_x_i, vertex_y_i};
    end
    if (issue) begin
      rd_data_q <= vtx_mem[rd_addr];
    end
  end

  // Edge indexes of the beat that just came back from memory
  assign cur_x  = rd_data_q[MW-1:COORD_W];
  assign cur_y  = rd_data_q[COORD_W-1:0];
  assign edge_i = tag_q - PW'(2);
  assign edge_j = (tag_q == PW'(n_q) + PW'(1)) ? '0 : tag_q - PW'(1);
  assign skip   = (edge_i == PW'(b_q)) || (edge_j == PW'(b_q));

  // Cross product tail: subtract, take magnitude
  assign cross_val = {p1_q[PRW-1], p1_q} - {p2_q[PRW-1], p2_q};
  assign cross_abs = cross_val[XW-1] ? XW'(-cross_val) : XW'(cross_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      thr_q      <= DEF_MIN_AREA;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      n_q        <= '0;
      b_q        <= '0;
      pos_q      <= '0;
      ok_q       <= 1'b1;
      rd_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      rv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= issue;
      s1_valid_q <= rd_valid_q && (tag_q >= PW'(2));
      s2_valid_q <= s1_valid_q;
      rv_q       <= 1'b0;

      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end

      // Count loaded vertices, note overflow
      if (accept) begin
        if (last_vertex_i) begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          cnt_q <= n_new;
          ovf_q <= ovf_new;
        end
      end

      // Advance the read position
      if (issue) begin
        pos_q <= last_issue ? '0 : pos_q + PW'(1);
      end

      // Start, reject or advance a candidate base
      if (start_search) begin
        n_q  <= n_new;
        b_q  <= '0;
        pos_q <= '0;
        ok_q <= 1'b1;
      end else if ((state_q == ST_DRAIN) && pipe_empty && !ok_q && !last_base) begin
        b_q  <= b_q + AW'(1);
        ok_q <= 1'b1;
      end else if (s2_valid_q && !s2_skip_q && (cross_abs <= XW'(thr_q))) begin
        ok_q <= 1'b0;
      end

      // Drive the one-cycle result beat
      if (accept && last_vertex_i) begin
        if (ovf_new) begin
          rv_q <= 1'b1;
        end else if (n_new <= CW'(SMALL_POLY)) begin
          rv_q <= 1'b1;
        end
      end
      if (search_done) begin
        rv_q <= 1'b1;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && last_vertex_i) begin
      if (ovf_new) begin
        found_q <= 1'b0;
        ridx_q  <= '0;
        rcnt_q  <= '0;
        rovf_q  <= 1'b1;
      end else begin
        found_q <= 1'b1;
        ridx_q  <= '0;
        rcnt_q  <= CNT_W'(n_new);
        rovf_q  <= 1'b0;
      end
    end
    if (search_done) begin
      rovf_q <= 1'b0;
      if (ok_q) begin
        found_q <= 1'b1;
        ridx_q  <= IDX_W'(b_q);
        rcnt_q  <= CNT_W'(n_q);
      end else begin
        found_q <= 1'b0;
        ridx_q  <= '0;
        rcnt_q  <= CNT_W'({1'b0, n_q} + PW'(2));
      end
    end
  end

  // Datapath: tag, differences, products
  always_ff @(posedge clk_i) begin
    if (issue) begin
      tag_q <= pos_q;
    end
    if (rd_valid_q) begin
      if (tag_q == '0) begin
        base_x_q <= cur_x;
        base_y_q <= cur_y;
      end else begin
        prev_x_q <= cur_x;
        prev_y_q <= cur_y;
      end
    end
    ax_q      <= {prev_x_q[COORD_W-1], prev_x_q} - {base_x_q[COORD_W-1], base_x_q};
    ay_q      <= {prev_y_q[COORD_W-1], prev_y_q} - {base_y_q[COORD_W-1], base_y_q};
    bx_q      <= {cur_x[COORD_W-1], cur_x} - {base_x_q[COORD_W-1], base_x_q};
    by_q      <= {cur_y[COORD_W-1], cur_y} - {base_y_q[COORD_W-1], base_y_q};
    s1_skip_q <= skip;
    p1_q      <= ax_q * by_q;
    p2_q      <= bx_q * ay_q;
    s2_skip_q <= s1_skip_q;
  end

  assign result_valid_o     = rv_q;
  assign base_found_o       = found_q;
  assign base_index_o       = ridx_q;
  assign fan_vertex_count_o = rcnt_q;
  assign overflow_o         = rovf_q;

endmodule
